// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
// ASSERT_CLK is disabled while rst_n is low; ASSERT_ALWAYS also checks during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(name, prop)
`define ASSERT_ALWAYS(name, prop)
`endif
`endif

// ===== rtl/core/cbs_pkg.sv =====
`default_nettype none
package cbs_pkg;

  localparam logic [1:0] REG_POLL_MODE    = 2'd0;
  localparam logic [1:0] REG_CAREFUL_MODE = 2'd1;
  localparam logic [1:0] REG_CHAR_LIMIT   = 2'd2;
  localparam logic [1:0] REG_STROBE_WAIT  = 2'd3;

  localparam logic [1:0] FAULT_TIMEOUT  = 2'd0;
  localparam logic [1:0] FAULT_PAPER    = 2'd1;
  localparam logic [1:0] FAULT_OFFLINE  = 2'd2;
  localparam logic [1:0] FAULT_PRN_ERR  = 2'd3;

  localparam logic [15:0] CHAR_LIMIT_RST = 16'd1000;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_POLL   = 4'b0010,
    PH_SETUP  = 4'b0100,
    PH_STROBE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] status_pins;
    logic       send_valid;
    logic [7:0] send_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic        strobe_res;
    logic        idle;
    logic        byte_done;
    logic        byte_failed;
    logic [1:0]  fault_code;
    logic [15:0] max_wait;
    logic [23:0] mean_wait;
    logic [23:0] mean_dev;
    logic [31:0] chars_sent;
  } out_word_t;

  typedef struct packed {
    logic        poll_mode;
    logic        careful_mode;
    logic [15:0] char_limit;
    logic [15:0] strobe_wait;
  } cfg_t;

  // Per-tick line and pulse results from the handshake machine.
  typedef struct packed {
    logic [7:0] data_out;
    logic       strobe_res;
    logic       idle;
    logic       byte_done;
    logic       byte_failed;
    logic [1:0] fault_code;
  } ctrl_res_t;

  // Statistic events raised by the handshake machine.
  typedef struct packed {
    logic sent_inc;
    logic stats_upd;
  } ctrl_evt_t;

  typedef struct packed {
    logic [15:0] max_wait;
    logic [23:0] mean_wait;
    logic [23:0] mean_dev;
    logic [31:0] chars_sent;
  } stats_t;

endpackage
`default_nettype wire

// ===== rtl/core/cbs_ctrl.sv =====
`default_nettype none
module cbs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire cbs_pkg::in_word_t in_word,
  input  wire cbs_pkg::cfg_t    cfg,
  output cbs_pkg::ctrl_res_t    res,
  output cbs_pkg::ctrl_evt_t    evt,
  output logic [15:0]           poll_count
);

  cbs_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] poll_r, poll_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  latch_r, latch_nxt;

  logic [7:0]  st;
  logic [15:0] lim, hold, pc1, tick1;
  logic        busy_ok, careful_ok, ready;
  logic [1:0]  fault;

  assign st         = in_word.status_pins;
  assign lim        = (cfg.char_limit == 16'd0) ? 16'd1 : cfg.char_limit;
  assign hold       = (cfg.strobe_wait == 16'd0) ? 16'd1 : cfg.strobe_wait;
  assign busy_ok    = st[7];
  assign careful_ok = st[7] & ~st[5] & st[4] & st[3];
  assign ready      = (cfg.poll_mode && cfg.careful_mode) ? careful_ok : busy_ok;
  assign tick1      = tick_r + 16'd1;

  // Paper out first, then offline, then printer error.
  always_comb begin
    if (st[5]) begin
      fault = cbs_pkg::FAULT_PAPER;
    end else if (!st[4]) begin
      fault = cbs_pkg::FAULT_OFFLINE;
    end else if (!st[3]) begin
      fault = cbs_pkg::FAULT_PRN_ERR;
    end else begin
      fault = cbs_pkg::FAULT_TIMEOUT;
    end
  end

  always_comb begin
    logic do_poll;
    phase_nxt = phase_r;
    poll_nxt  = poll_r;
    tick_nxt  = tick_r;
    latch_nxt = latch_r;
    res       = '0;
    evt       = '0;
    do_poll   = 1'b0;
    pc1       = poll_r + 16'd1;

    case (phase_r)
      cbs_pkg::PH_IDLE: begin
        if (in_word.send_valid) begin
          latch_nxt = in_word.send_byte;
          pc1       = 16'd1;
          do_poll   = 1'b1;
        end
      end
      cbs_pkg::PH_POLL: begin
        do_poll = 1'b1;
      end
      cbs_pkg::PH_SETUP: begin
        tick_nxt = tick1;
        if (tick1 >= cfg.strobe_wait) begin
          tick_nxt  = '0;
          phase_nxt = cbs_pkg::PH_STROBE;
        end
      end
      cbs_pkg::PH_STROBE: begin
        res.strobe_res = 1'b1;
        tick_nxt       = tick1;
        if (tick1 >= hold) begin
          evt.stats_upd = 1'b1;
          res.byte_done = 1'b1;
          tick_nxt      = '0;
          phase_nxt     = cbs_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = cbs_pkg::PH_IDLE;
      end
    endcase

    if (do_poll) begin
      poll_nxt  = pc1;
      phase_nxt = cbs_pkg::PH_POLL;
      if (ready || pc1 >= lim) begin
        if (pc1 == lim || (!cfg.poll_mode && cfg.careful_mode && !careful_ok)) begin
          res.byte_failed = 1'b1;
          res.fault_code  = fault;
          phase_nxt       = cbs_pkg::PH_IDLE;
        end else begin
          evt.sent_inc = 1'b1;
          tick_nxt     = '0;
          phase_nxt    = (cfg.strobe_wait != 16'd0) ? cbs_pkg::PH_SETUP
                                                    : cbs_pkg::PH_STROBE;
        end
      end
    end

    res.data_out = latch_nxt;
    res.idle     = (phase_nxt == cbs_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cbs_pkg::PH_IDLE;
      poll_r  <= '0;
      tick_r  <= '0;
      latch_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      poll_r  <= poll_nxt;
      tick_r  <= tick_nxt;
      latch_r <= latch_nxt;
    end
  end

  assign poll_count = poll_r;

endmodule
`default_nettype wire

// ===== rtl/core/cbs_stats.sv =====
`default_nettype none
module cbs_stats (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire cbs_pkg::ctrl_evt_t evt,
  input  wire logic [15:0]       poll_count,
  output cbs_pkg::stats_t        stats_nxt
);

  logic [15:0] worst_r, worst_nxt;
  logic [23:0] avg_r, avg_nxt;
  logic [23:0] dev_r, dev_nxt;
  logic [31:0] sent_r, sent_nxt;

  logic [23:0] c, d;
  logic [32:0] wsum;
  logic [31:0] dsum;

  assign c = {poll_count, 8'd0};
  assign d = (c > avg_r) ? (c - avg_r) : (avg_r - c);

  // mean*255/256 and dev*127/128 written as shift-and-subtract, rounded.
  assign wsum = ({1'b0, avg_r, 8'd0} - {9'd0, avg_r}) + {9'd0, c} + 33'd128;
  assign dsum = ({1'b0, dev_r, 7'd0} - {8'd0, dev_r}) + {8'd0, d} + 32'd64;

  always_comb begin
    worst_nxt = worst_r;
    avg_nxt   = avg_r;
    dev_nxt   = dev_r;
    sent_nxt  = sent_r;
    if (evt.stats_upd) begin
      if (poll_count > worst_r) begin
        worst_nxt = poll_count;
      end
      avg_nxt = wsum[31:8];
      dev_nxt = dsum[30:7];
    end
    if (evt.sent_inc) begin
      sent_nxt = sent_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worst_r <= '0;
      avg_r   <= '0;
      dev_r   <= '0;
      sent_r  <= '0;
    end else if (adv) begin
      worst_r <= worst_nxt;
      avg_r   <= avg_nxt;
      dev_r   <= dev_nxt;
      sent_r  <= sent_nxt;
    end
  end

  assign stats_nxt.max_wait   = worst_nxt;
  assign stats_nxt.mean_wait  = avg_nxt;
  assign stats_nxt.mean_dev   = dev_nxt;
  assign stats_nxt.chars_sent = sent_nxt;

endmodule
`default_nettype wire

// ===== rtl/core/centronics_byte_sender_top.sv =====
// Centronics byte sender: drives one parallel printer port, one status
// sample per input word.
// Input channel (in_valid / in_stall / in_word): each word carries the
// status pin sample and an optional byte offer; the offer is taken only
// when the sender is idle. Output channel (out_valid / out_stall /
// out_word): exactly one word per input word, holding the data lines,
// strobe, idle flag, done/failed pulses, fault class and statistics.
// The output word is registered on input accept. Throughput: one word per
// cycle while the output is not stalled; all per-tick work is one pass of
// logic between the state registers and the output register.
// When the receiver stalls, the output word holds and in_stall rises only
// while a held word is pending, so a word is still taken in the cycle the
// pending one leaves.
// Configuration (cfg_we / cfg_index / cfg_data) writes poll mode, careful
// mode, char limit and strobe wait; write only while idle.
// Reset (rst_n low, synchronous) returns the sender to idle, clears the
// counters and statistics, and loads the register defaults.
`default_nettype none
`include "assert_macros.svh"
module centronics_byte_sender_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cbs_pkg::in_word_t in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cbs_pkg::out_word_t     out_word,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);

  cbs_pkg::cfg_t      cfg_r;
  cbs_pkg::ctrl_res_t res;
  cbs_pkg::ctrl_evt_t evt;
  cbs_pkg::stats_t    stats_nxt;
  logic [15:0]        poll_count;
  logic               adv;

  logic               out_valid_r, out_valid_nxt;
  cbs_pkg::out_word_t out_word_r, out_word_nxt;

  // Stall input only while a word is waiting and the receiver holds it.
  assign in_stall = out_valid_r & out_stall;
  assign adv      = in_valid & ~in_stall;

  // Config registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_mode    <= 1'b1;
      cfg_r.careful_mode <= 1'b0;
      cfg_r.char_limit   <= cbs_pkg::CHAR_LIMIT_RST;
      cfg_r.strobe_wait  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbs_pkg::REG_POLL_MODE:    cfg_r.poll_mode    <= cfg_data[0];
        cbs_pkg::REG_CAREFUL_MODE: cfg_r.careful_mode <= cfg_data[0];
        cbs_pkg::REG_CHAR_LIMIT:   cfg_r.char_limit   <= cfg_data;
        cbs_pkg::REG_STROBE_WAIT:  cfg_r.strobe_wait  <= cfg_data;
        default: ;
      endcase
    end
  end

  cbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_word    (in_word),
    .cfg        (cfg_r),
    .res        (res),
    .evt        (evt),
    .poll_count (poll_count)
  );

  cbs_stats u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .evt        (evt),
    .poll_count (poll_count),
    .stats_nxt  (stats_nxt)
  );

  // Assemble the result word from the line results and updated statistics.
  always_comb begin
    out_word_nxt.data_out    = res.data_out;
    out_word_nxt.strobe_res  = res.strobe_res;
    out_word_nxt.idle        = res.idle;
    out_word_nxt.byte_done   = res.byte_done;
    out_word_nxt.byte_failed = res.byte_failed;
    out_word_nxt.fault_code  = res.fault_code;
    out_word_nxt.max_wait    = stats_nxt.max_wait;
    out_word_nxt.mean_wait   = stats_nxt.mean_wait;
    out_word_nxt.mean_dev    = stats_nxt.mean_dev;
    out_word_nxt.chars_sent  = stats_nxt.chars_sent;
  end

  // Load on accept, drop when taken, hold while stalled.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `ASSERT_CLK(a_done_xor_fail, out_valid |-> !(out_word.byte_done && out_word.byte_failed))
  `ASSERT_CLK(a_strobe_idle_done, (out_valid && out_word.strobe_res && out_word.idle) |-> out_word.byte_done)
  `ASSERT_CLK(a_fault_only_on_fail, (out_valid && out_word.fault_code != cbs_pkg::FAULT_TIMEOUT) |-> out_word.byte_failed)
  `ASSERT_ALWAYS(a_stall_needs_word, in_stall |-> out_valid)

endmodule
`default_nettype wire
